### rtl/core/gkeq_pkg.sv
// ----------------------------------------------------------------------------
// gkeq_pkg
// Shared widths, register indexes, key codes and reset values for the
// gamepad key event qualifier.
// ----------------------------------------------------------------------------
package gkeq_pkg;

   localparam int BUTTON_COUNT = 7;
   localparam int AXIS_W       = 8;
   localparam int DZ_W         = 7;
   localparam int DELAY_W      = 10;
   localparam int TIMER_W      = 12;
   localparam int KEY_W        = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 10;
   // button edges, stick, D-pad X, D-pad Y
   localparam int EVENT_SLOTS  = BUTTON_COUNT + 3;
   localparam int STICK_SLOT   = BUTTON_COUNT;
   localparam int DPAD_X_SLOT  = BUTTON_COUNT + 1;
   localparam int DPAD_Y_SLOT  = BUTTON_COUNT + 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEAD_ZONE         = 2'd0,
      CSR_TRIGGER_DEAD_ZONE = 2'd1,
      CSR_REPEAT_DELAY      = 2'd2
   } csr_index_type;

   localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
   localparam logic [KEY_W-1:0] KEY_UP    = 4'd7;
   localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd8;
   localparam logic [KEY_W-1:0] KEY_RIGHT = 4'd9;
   localparam logic [KEY_W-1:0] KEY_LEFT  = 4'd10;

   localparam logic [DZ_W-1:0]    DEAD_ZONE_RST         = 7'd20;
   localparam logic [DZ_W-1:0]    TRIGGER_DEAD_ZONE_RST = 7'd5;
   localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST      = 10'd200;

   localparam logic signed [TIMER_W-1:0] TIMER_FLOOR    = -12'sd2048;
   localparam logic signed [TIMER_W-1:0] TIMER_CENTERED = -12'sd1000;

   // Zero an axis whose magnitude is strictly below the dead zone.
   function automatic logic signed [AXIS_W-1:0] zone_axis(
      input logic signed [AXIS_W-1:0] v,
      input logic [DZ_W-1:0]          dz
   );
      logic signed [AXIS_W:0] ext;
      logic signed [AXIS_W:0] mag;
      begin
         ext = {v[AXIS_W-1], v};
         mag = ext[AXIS_W] ? -ext : ext;
         zone_axis = ($unsigned(mag) < {2'b00, dz}) ? '0 : v;
      end
   endfunction

endpackage

### rtl/core/gamepad_key_event_qualifier.sv
// ----------------------------------------------------------------------------
// gamepad_key_event_qualifier
// Turns one gamepad poll into key press events plus dead-zoned held levels.
// ----------------------------------------------------------------------------
// Path: a poll passes through the input register, the event register and the
//   result register before its results are presented.
// Throughput: one result per cycle unless rsp_stall; a poll yields 1 to 10
//   results, the next poll entering the event register as its last one leaves.
// Reset: synchronous; restores register defaults, arms all buttons, stick and
//   D-pad axes, clears the repeat timer and held levels. No clearing pass.
module gamepad_key_event_qualifier (
   input  logic                                 clock,
   input  logic                                 reset,
   // poll channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_connected,
   input  logic [gkeq_pkg::BUTTON_COUNT-1:0]    req_buttons,
   input  logic signed [gkeq_pkg::AXIS_W-1:0]   req_stick_x,
   input  logic signed [gkeq_pkg::AXIS_W-1:0]   req_stick_y,
   input  logic signed [gkeq_pkg::AXIS_W-1:0]   req_dpad_x,
   input  logic signed [gkeq_pkg::AXIS_W-1:0]   req_dpad_y,
   input  logic signed [gkeq_pkg::AXIS_W-1:0]   req_trigger,
   input  logic [gkeq_pkg::DELAY_W-1:0]         req_elapsed_ms,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_event_valid,
   output logic [gkeq_pkg::KEY_W-1:0]           rsp_key_code,
   output logic                                 rsp_last,
   output logic signed [gkeq_pkg::AXIS_W-1:0]   rsp_stick_x_level,
   output logic signed [gkeq_pkg::AXIS_W-1:0]   rsp_trigger_level,
   output logic                                 rsp_button_a_level,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gkeq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gkeq_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NB = gkeq_pkg::BUTTON_COUNT;
   localparam int AW = gkeq_pkg::AXIS_W;
   localparam int NS = gkeq_pkg::EVENT_SLOTS;
   localparam int TW = gkeq_pkg::TIMER_W;
   localparam int KW = gkeq_pkg::KEY_W;

   // ---------------- configuration registers ----------------
   logic [gkeq_pkg::DZ_W-1:0]    dead_zone_ff;
   logic [gkeq_pkg::DZ_W-1:0]    trig_dead_zone_ff;
   logic [gkeq_pkg::DELAY_W-1:0] repeat_delay_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff      <= gkeq_pkg::DEAD_ZONE_RST;
         trig_dead_zone_ff <= gkeq_pkg::TRIGGER_DEAD_ZONE_RST;
         repeat_delay_ff   <= gkeq_pkg::REPEAT_DELAY_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (gkeq_pkg::csr_index_type'(csr_index))
            gkeq_pkg::CSR_DEAD_ZONE: begin
               dead_zone_ff <= csr_wdata[gkeq_pkg::DZ_W-1:0];
            end
            gkeq_pkg::CSR_TRIGGER_DEAD_ZONE: begin
               trig_dead_zone_ff <= csr_wdata[gkeq_pkg::DZ_W-1:0];
            end
            gkeq_pkg::CSR_REPEAT_DELAY: begin
               repeat_delay_ff <= csr_wdata[gkeq_pkg::DELAY_W-1:0];
            end
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                            in_valid_ff;
   logic                            in_conn_ff;
   logic [NB-1:0]                   in_btn_ff;
   logic signed [AW-1:0]            in_sx_ff;
   logic signed [AW-1:0]            in_sy_ff;
   logic signed [AW-1:0]            in_dx_ff;
   logic signed [AW-1:0]            in_dy_ff;
   logic signed [AW-1:0]            in_tr_ff;
   logic [gkeq_pkg::DELAY_W-1:0]    in_el_ff;

   logic in_load;
   logic pend_load;

   assign in_load   = !in_valid_ff || pend_load;
   assign req_stall = !in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_conn_ff <= req_connected;
         in_btn_ff  <= req_buttons;
         in_sx_ff   <= req_stick_x;
         in_sy_ff   <= req_stick_y;
         in_dx_ff   <= req_dpad_x;
         in_dy_ff   <= req_dpad_y;
         in_tr_ff   <= req_trigger;
         in_el_ff   <= req_elapsed_ms;
      end
   end

   // ---------------- qualifier state ----------------
   logic [NB-1:0]           button_armed_ff;
   logic                    stick_armed_ff;
   logic signed [TW-1:0]    timer_ff;
   logic                    dpad_x_armed_ff;
   logic                    dpad_y_armed_ff;
   logic signed [AW-1:0]    held_sx_ff;
   logic signed [AW-1:0]    held_tl_ff;
   logic                    held_a_ff;

   logic [NB-1:0]           button_armed_in;
   logic                    stick_armed_in;
   logic signed [TW-1:0]    timer_in;
   logic                    dpad_x_armed_in;
   logic                    dpad_y_armed_in;
   logic signed [AW-1:0]    held_sx_in;
   logic signed [AW-1:0]    held_tl_in;
   logic                    held_a_in;

   // event set computed for the poll in the input register
   logic [NS-1:0]           new_mask;
   logic [KW-1:0]           new_stick_code;
   logic [KW-1:0]           new_dx_code;
   logic [KW-1:0]           new_dy_code;

   logic signed [AW-1:0]    sx_z;
   logic signed [AW-1:0]    dx_z;
   logic signed [AW-1:0]    dy_z;
   logic signed [AW-1:0]    tr_z;
   logic signed [AW:0]      sx9;
   logic signed [AW:0]      sy9;
   logic signed [AW:0]      tl9;
   logic signed [AW:0]      dz9;
   logic signed [TW:0]      t13;
   logic signed [TW-1:0]    t_dec;
   logic                    go;
   logic                    st_up;
   logic                    st_down;
   logic                    st_right;
   logic                    st_left;
   logic                    st_center;
   logic [NB-1:0]           btn_fire;

   always_comb begin
      sx_z = gkeq_pkg::zone_axis(in_sx_ff, dead_zone_ff);
      dx_z = gkeq_pkg::zone_axis(in_dx_ff, dead_zone_ff);
      dy_z = gkeq_pkg::zone_axis(in_dy_ff, dead_zone_ff);
      tr_z = gkeq_pkg::zone_axis(in_tr_ff, trig_dead_zone_ff);

      sx9 = {sx_z[AW-1], sx_z};
      sy9 = {in_sy_ff[AW-1], in_sy_ff};
      dz9 = $signed({2'b00, dead_zone_ff});

      // invert trigger, saturate the single overflow case
      tl9 = -$signed({tr_z[AW-1], tr_z});
      held_tl_in = (tl9 > $signed((AW+1)'(127))) ? AW'(127) : tl9[AW-1:0];
      held_sx_in = sx_z;
      held_a_in  = in_btn_ff[0];

      // advance the repeat timer, clamp at the floor
      t13   = {timer_ff[TW-1], timer_ff} - $signed({3'b000, in_el_ff});
      t_dec = (t13 < $signed({gkeq_pkg::TIMER_FLOOR[TW-1], gkeq_pkg::TIMER_FLOOR}))
              ? gkeq_pkg::TIMER_FLOOR : t13[TW-1:0];

      btn_fire        = in_btn_ff & button_armed_ff;
      button_armed_in = ~in_btn_ff;

      go        = stick_armed_ff || t_dec[TW-1];
      st_up     = sy9 < -dz9;
      st_down   = sy9 > dz9;
      st_right  = sx9 > dz9;
      st_left   = sx9 < -dz9;
      st_center = (sx9 > -dz9) && (sx9 < dz9) && (sy9 > -dz9) && (sy9 < dz9);

      new_stick_code = gkeq_pkg::KEY_LEFT;
      priority if (st_up) begin
         new_stick_code = gkeq_pkg::KEY_UP;
      end else if (st_down) begin
         new_stick_code = gkeq_pkg::KEY_DOWN;
      end else if (st_right) begin
         new_stick_code = gkeq_pkg::KEY_RIGHT;
      end else begin
         new_stick_code = gkeq_pkg::KEY_LEFT;
      end

      new_mask = '0;
      new_mask[NB-1:0] = btn_fire;
      stick_armed_in = stick_armed_ff;
      timer_in       = t_dec;
      if (go && (st_up || st_down || st_right || st_left)) begin
         new_mask[gkeq_pkg::STICK_SLOT] = 1'b1;
         stick_armed_in = 1'b0;
         timer_in       = $signed({2'b00, repeat_delay_ff});
      end else if (st_center) begin
         stick_armed_in = 1'b1;
         timer_in       = gkeq_pkg::TIMER_CENTERED;
      end

      new_dx_code = dx_z[AW-1] ? gkeq_pkg::KEY_LEFT : gkeq_pkg::KEY_RIGHT;
      new_dy_code = dy_z[AW-1] ? gkeq_pkg::KEY_DOWN : gkeq_pkg::KEY_UP;
      new_mask[gkeq_pkg::DPAD_X_SLOT] = (dx_z != '0) && dpad_x_armed_ff;
      new_mask[gkeq_pkg::DPAD_Y_SLOT] = (dy_z != '0) && dpad_y_armed_ff;
      dpad_x_armed_in = (dx_z == '0) ? 1'b1
                        : (dpad_x_armed_ff && !new_mask[gkeq_pkg::DPAD_X_SLOT]);
      dpad_y_armed_in = (dy_z == '0) ? 1'b1
                        : (dpad_y_armed_ff && !new_mask[gkeq_pkg::DPAD_Y_SLOT]);

      // a disconnected pad reports no key events
      if (!in_conn_ff) begin
         new_mask = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         button_armed_ff <= '1;
         stick_armed_ff  <= 1'b1;
         timer_ff        <= '0;
         dpad_x_armed_ff <= 1'b1;
         dpad_y_armed_ff <= 1'b1;
         held_sx_ff      <= '0;
         held_tl_ff      <= '0;
         held_a_ff       <= 1'b0;
      end else if (pend_load && in_conn_ff) begin
         button_armed_ff <= button_armed_in;
         stick_armed_ff  <= stick_armed_in;
         timer_ff        <= timer_in;
         dpad_x_armed_ff <= dpad_x_armed_in;
         dpad_y_armed_ff <= dpad_y_armed_in;
         held_sx_ff      <= held_sx_in;
         held_tl_ff      <= held_tl_in;
         held_a_ff       <= held_a_in;
      end
   end

   // ---------------- pending event register ----------------
   logic                    pend_valid_ff;
   logic [NS-1:0]           pend_mask_ff;
   logic [KW-1:0]           pend_stick_code_ff;
   logic [KW-1:0]           pend_dx_code_ff;
   logic [KW-1:0]           pend_dy_code_ff;
   logic signed [AW-1:0]    pend_sx_ff;
   logic signed [AW-1:0]    pend_tl_ff;
   logic                    pend_a_ff;

   logic                    out_load;
   logic [NS-1:0]           sel_oh;
   logic [NS-1:0]           rest_mask;
   logic [KW-1:0]           sel_code;
   logic                    pend_done;

   always_comb begin
      // isolate the earliest pending event
      sel_oh    = pend_mask_ff & (~pend_mask_ff + NS'(1));
      rest_mask = pend_mask_ff & ~sel_oh;
      sel_code  = gkeq_pkg::KEY_NONE;
      for (int i = 0; i < NB; i++) begin
         if (sel_oh[i]) begin
            sel_code = KW'(i);
         end
      end
      if (sel_oh[gkeq_pkg::STICK_SLOT]) begin
         sel_code = pend_stick_code_ff;
      end
      if (sel_oh[gkeq_pkg::DPAD_X_SLOT]) begin
         sel_code = pend_dx_code_ff;
      end
      if (sel_oh[gkeq_pkg::DPAD_Y_SLOT]) begin
         sel_code = pend_dy_code_ff;
      end
   end

   assign out_load  = !rsp_valid || !rsp_stall;
   assign pend_done = pend_valid_ff && out_load && (rest_mask == '0);
   assign pend_load = in_valid_ff && (!pend_valid_ff || pend_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_mask_ff  <= '0;
      end else if (pend_load) begin
         pend_valid_ff <= 1'b1;
         pend_mask_ff  <= new_mask;
      end else if (pend_valid_ff && out_load) begin
         pend_valid_ff <= (rest_mask != '0);
         pend_mask_ff  <= rest_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_load) begin
         pend_stick_code_ff <= new_stick_code;
         pend_dx_code_ff    <= new_dx_code;
         pend_dy_code_ff    <= new_dy_code;
         pend_sx_ff         <= in_conn_ff ? held_sx_in : held_sx_ff;
         pend_tl_ff         <= in_conn_ff ? held_tl_in : held_tl_ff;
         pend_a_ff          <= in_conn_ff ? held_a_in  : held_a_ff;
      end
   end

   // ---------------- result register ----------------
   logic                    rsp_valid_ff;
   logic                    rsp_event_valid_ff;
   logic [KW-1:0]           rsp_key_code_ff;
   logic                    rsp_last_ff;
   logic signed [AW-1:0]    rsp_sx_ff;
   logic signed [AW-1:0]    rsp_tl_ff;
   logic                    rsp_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && pend_valid_ff) begin
         rsp_event_valid_ff <= (pend_mask_ff != '0);
         rsp_key_code_ff    <= sel_code;
         rsp_last_ff        <= (rest_mask == '0);
         rsp_sx_ff          <= pend_sx_ff;
         rsp_tl_ff          <= pend_tl_ff;
         rsp_a_ff           <= pend_a_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_valid    = rsp_event_valid_ff;
   assign rsp_key_code       = rsp_key_code_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_stick_x_level  = rsp_sx_ff;
   assign rsp_trigger_level  = rsp_tl_ff;
   assign rsp_button_a_level = rsp_a_ff;

   // ---------------- assertions ----------------
   a_no_event_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_last && (rsp_key_code == gkeq_pkg::KEY_NONE))
      else $error("no-event result must be last with key code zero");

   a_pend_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      pend_load |-> !pend_valid_ff || (out_load && rest_mask == '0))
      else $error("pending events overwritten before drained");

   a_disconnected_holds_state: assert property (@(posedge clock) disable iff (reset)
      pend_load && !in_conn_ff |=> $stable(button_armed_ff) && $stable(timer_ff)
         && $stable(stick_armed_ff))
      else $error("disconnected poll changed qualifier state");

   a_stick_event_disarms: assert property (@(posedge clock) disable iff (reset)
      pend_load && new_mask[gkeq_pkg::STICK_SLOT] |=> !stick_armed_ff)
      else $error("stick event left the stick armed");

endmodule

### verif/tb_gamepad_key_event_qualifier.sv
// ----------------------------------------------------------------------------
// tb_gamepad_key_event_qualifier
// Self-checking bench for the gamepad key event qualifier. A scoreboard
// predicts the event list of every accepted poll (button edges, stick
// auto-repeat, D-pad, dead zones and held levels) and checks each result in
// order. The bench runs a directed sequence and then random phases under
// several register settings and idling profiles.
// ----------------------------------------------------------------------------
module tb_gamepad_key_event_qualifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB  = gkeq_pkg::BUTTON_COUNT;
   localparam int AW  = gkeq_pkg::AXIS_W;
   localparam int DZW = gkeq_pkg::DZ_W;
   localparam int DW  = gkeq_pkg::DELAY_W;
   localparam int TW  = gkeq_pkg::TIMER_W;
   localparam int KW  = gkeq_pkg::KEY_W;
   localparam int CIW = gkeq_pkg::CSR_INDEX_W;
   localparam int CDW = gkeq_pkg::CSR_DATA_W;

   localparam logic [CIW-1:0] CSR_UNMAPPED = 2'd3;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_POLLS    = 58;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic                  connected;
      logic [NB-1:0]         buttons;
      logic signed [AW-1:0]  stick_x;
      logic signed [AW-1:0]  stick_y;
      logic signed [AW-1:0]  dpad_x;
      logic signed [AW-1:0]  dpad_y;
      logic signed [AW-1:0]  trigger;
      logic [DW-1:0]         elapsed_ms;
   } poll_type;

   typedef struct {
      logic                  event_valid;
      logic [KW-1:0]         key_code;
      logic                  last;
      logic signed [AW-1:0]  stick_x_level;
      logic signed [AW-1:0]  trigger_level;
      logic                  button_a_level;
   } key_result_type;

   class key_event_scoreboard;
      logic [DZW-1:0]         dead_zone;
      logic [DZW-1:0]         trigger_dead_zone;
      logic [DW-1:0]          repeat_delay;
      logic [NB-1:0]          button_armed;
      bit                     stick_armed;
      logic signed [TW-1:0]   repeat_timer;
      bit                     dpad_x_armed;
      bit                     dpad_y_armed;
      logic signed [AW-1:0]   held_stick_x;
      logic signed [AW-1:0]   held_trigger;
      bit                     held_button_a;
      key_result_type         expected_events[$];
      int                     mismatch_count;

      function new();
         dead_zone         = gkeq_pkg::DEAD_ZONE_RST;
         trigger_dead_zone = gkeq_pkg::TRIGGER_DEAD_ZONE_RST;
         repeat_delay      = gkeq_pkg::REPEAT_DELAY_RST;
         button_armed      = '1;
         stick_armed       = 1'b1;
         repeat_timer      = '0;
         dpad_x_armed      = 1'b1;
         dpad_y_armed      = 1'b1;
         held_stick_x      = '0;
         held_trigger      = '0;
         held_button_a     = 1'b0;
         mismatch_count    = 0;
      endfunction

      function void set_register(logic [CIW-1:0] idx, logic [CDW-1:0] value);
         case (idx)
            gkeq_pkg::CSR_DEAD_ZONE:         dead_zone = value[DZW-1:0];
            gkeq_pkg::CSR_TRIGGER_DEAD_ZONE: trigger_dead_zone = value[DZW-1:0];
            gkeq_pkg::CSR_REPEAT_DELAY:      repeat_delay = value[DW-1:0];
            default: ;
         endcase
      endfunction

      function int dead_zoned(int v, int thr);
         int m;
         m = (v < 0) ? -v : v;
         return (m < thr) ? 0 : v;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void flag(string what);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) $display("ERROR: %s", what);
      endfunction

      // Work out the event list of one accepted poll and advance the state.
      function void note_poll(poll_type p);
         logic [KW-1:0] codes[$];
         key_result_type r;
         int dz, sx, sy, dx, dy, tr, t, tl, i;
         bit go;
         if (p.connected) begin
            dz = int'(dead_zone);
            sx = dead_zoned(int'(p.stick_x), dz);
            sy = int'(p.stick_y);
            dx = dead_zoned(int'(p.dpad_x), dz);
            dy = dead_zoned(int'(p.dpad_y), dz);
            tr = dead_zoned(int'(p.trigger), int'(trigger_dead_zone));
            t = int'(repeat_timer);
            t -= int'(p.elapsed_ms);
            if (t < int'(gkeq_pkg::TIMER_FLOOR)) t = int'(gkeq_pkg::TIMER_FLOOR);
            held_stick_x  = AW'(sx);
            held_trigger  = AW'(tr);
            held_button_a = p.buttons[0];
            for (i = 0; i < NB; i++) begin
               if (p.buttons[i]) begin
                  if (button_armed[i]) begin
                     codes = {codes, KW'(i)};
                     button_armed[i] = 1'b0;
                  end
               end else begin
                  button_armed[i] = 1'b1;
               end
            end
            go = stick_armed || (t < 0);
            if (go && (sy < -dz || sy > dz || sx > dz || sx < -dz)) begin
               if (sy < -dz) codes = {codes, gkeq_pkg::KEY_UP};
               else if (sy > dz) codes = {codes, gkeq_pkg::KEY_DOWN};
               else if (sx > dz) codes = {codes, gkeq_pkg::KEY_RIGHT};
               else codes = {codes, gkeq_pkg::KEY_LEFT};
               stick_armed = 1'b0;
               t = int'(repeat_delay);
            end else if (sx > -dz && sx < dz && sy > -dz && sy < dz) begin
               stick_armed = 1'b1;
               t = int'(gkeq_pkg::TIMER_CENTERED);
            end
            repeat_timer = TW'(t);
            if (dx != 0 && dpad_x_armed) begin
               codes = {codes, (dx > 0) ? gkeq_pkg::KEY_RIGHT : gkeq_pkg::KEY_LEFT};
               dpad_x_armed = 1'b0;
            end else if (dx == 0) begin
               dpad_x_armed = 1'b1;
            end
            if (dy != 0 && dpad_y_armed) begin
               codes = {codes, (dy > 0) ? gkeq_pkg::KEY_UP : gkeq_pkg::KEY_DOWN};
               dpad_y_armed = 1'b0;
            end else if (dy == 0) begin
               dpad_y_armed = 1'b1;
            end
         end
         tl = int'(held_trigger);
         tl = -tl;
         if (tl > 127) tl = 127;
         r.stick_x_level  = held_stick_x;
         r.trigger_level  = AW'(tl);
         r.button_a_level = held_button_a;
         if (codes.size() == 0) begin
            r.event_valid = 1'b0;
            r.key_code    = gkeq_pkg::KEY_NONE;
            r.last        = 1'b1;
            expected_events = {expected_events, r};
         end else begin
            for (i = 0; i < codes.size(); i++) begin
               r.event_valid = 1'b1;
               r.key_code    = codes[i];
               r.last        = (i == codes.size() - 1);
               expected_events = {expected_events, r};
            end
         end
      endfunction

      function void check_result(key_result_type got);
         key_result_type want;
         if (expected_events.size() == 0) begin
            flag($sformatf("unexpected result: event %0b key %0d", got.event_valid,
                           got.key_code));
            return;
         end
         want = expected_events.pop_front();
         if (got.event_valid !== want.event_valid)
            flag($sformatf("event_valid: expected %0b got %0b", want.event_valid,
                           got.event_valid));
         if (got.key_code !== want.key_code)
            flag($sformatf("key_code: expected %0d got %0d", want.key_code, got.key_code));
         if (got.last !== want.last)
            flag($sformatf("last: expected %0b got %0b", want.last, got.last));
         if (got.stick_x_level !== want.stick_x_level)
            flag($sformatf("stick_x_level: expected %0d got %0d", want.stick_x_level,
                           got.stick_x_level));
         if (got.trigger_level !== want.trigger_level)
            flag($sformatf("trigger_level: expected %0d got %0d", want.trigger_level,
                           got.trigger_level));
         if (got.button_a_level !== want.button_a_level)
            flag($sformatf("button_a_level: expected %0b got %0b", want.button_a_level,
                           got.button_a_level));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_connected = 1'b0;
   logic [NB-1:0]         req_buttons = '0;
   logic signed [AW-1:0]  req_stick_x = '0;
   logic signed [AW-1:0]  req_stick_y = '0;
   logic signed [AW-1:0]  req_dpad_x = '0;
   logic signed [AW-1:0]  req_dpad_y = '0;
   logic signed [AW-1:0]  req_trigger = '0;
   logic [DW-1:0]         req_elapsed_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_event_valid;
   logic [KW-1:0]         rsp_key_code;
   logic                  rsp_last;
   logic signed [AW-1:0]  rsp_stick_x_level;
   logic signed [AW-1:0]  rsp_trigger_level;
   logic                  rsp_button_a_level;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CIW-1:0]        csr_index = '0;
   logic [CDW-1:0]        csr_wdata = '0;

   key_event_scoreboard sb;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_armed = 1'b0;
   logic holding = 1'b0;
   int  quiet_cycles = 0;

   gamepad_key_event_qualifier dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_connected      (req_connected),
      .req_buttons        (req_buttons),
      .req_stick_x        (req_stick_x),
      .req_stick_y        (req_stick_y),
      .req_dpad_x         (req_dpad_x),
      .req_dpad_y         (req_dpad_y),
      .req_trigger        (req_trigger),
      .req_elapsed_ms     (req_elapsed_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_key_code       (rsp_key_code),
      .rsp_last           (rsp_last),
      .rsp_stick_x_level  (rsp_stick_x_level),
      .rsp_trigger_level  (rsp_trigger_level),
      .rsp_button_a_level (rsp_button_a_level),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (holding) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Long receiver hold-off so the block backs up into its input.
   initial begin : hold_off
      wait (hold_armed);
      @(posedge clock);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin : result_monitor
      key_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.event_valid    = rsp_event_valid;
         got.key_code       = rsp_key_code;
         got.last           = rsp_last;
         got.stick_x_level  = rsp_stick_x_level;
         got.trigger_level  = rsp_trigger_level;
         got.button_a_level = rsp_button_a_level;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic poll_type mk_poll(int conn, int btn, int sx, int sy, int dx, int dy,
                                        int tr, int el);
      poll_type p;
      p.connected  = conn[0];
      p.buttons    = NB'(btn);
      p.stick_x    = AW'(sx);
      p.stick_y    = AW'(sy);
      p.dpad_x     = AW'(dx);
      p.dpad_y     = AW'(dy);
      p.trigger    = AW'(tr);
      p.elapsed_ms = DW'(el);
      return p;
   endfunction

   // Mix of held values, dead-zone edges, full-scale and ordinary values.
   function automatic logic signed [AW-1:0] pick_axis(logic signed [AW-1:0] prev, int thr);
      int v;
      case ($urandom_range(9))
         0, 1, 2: v = int'(prev);
         3:       v = $urandom_range(1) ? thr : -thr;
         4:       v = (thr - 1 + int'($urandom_range(2))) * ($urandom_range(1) ? 1 : -1);
         5:       v = int'($urandom_range(255)) - 128;
         6:       v = 0;
         default: v = int'($urandom_range(200)) - 100;
      endcase
      return AW'(v);
   endfunction

   // Offer a poll and hold it until taken; valid stays high unless idling.
   task automatic send_poll(poll_type p);
      req_valid      <= 1'b1;
      req_connected  <= p.connected;
      req_buttons    <= p.buttons;
      req_stick_x    <= p.stick_x;
      req_stick_y    <= p.stick_y;
      req_dpad_x     <= p.dpad_x;
      req_dpad_y     <= p.dpad_y;
      req_trigger    <= p.trigger;
      req_elapsed_ms <= p.elapsed_ms;
      do @(posedge clock); while (req_stall);
      sb.note_poll(p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic write_register(logic [CIW-1:0] idx, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CDW'(value);
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, CDW'(value));
   endtask

   // Drop valid and wait on the clock until every result is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin : main
      poll_type p;
      int ph, i, dz_cfg, tdz_cfg, delay_cfg;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sequence at reset settings: dead zone 20, trigger 5, delay 200.
      send_poll(mk_poll(1, 0, 0, 0, 0, 0, 0, 0));
      send_poll(mk_poll(1, 127, 0, -100, 100, 100, 100, 0));      // every event at once
      send_poll(mk_poll(1, 127, 0, -100, 100, 100, -100, 0));     // all held, silent
      send_poll(mk_poll(1, 127, 0, -100, 100, 100, 0, 1000));     // stick repeats
      send_poll(mk_poll(0, 0, 50, 50, -100, -100, 127, 1000));    // pad gone
      send_poll(mk_poll(1, 0, 0, 100, 0, 0, -128, 1000));         // trigger saturates
      send_poll(mk_poll(1, 1, 0, 0, -100, -100, 127, 0));
      send_poll(mk_poll(1, 0, 100, 0, 0, 0, 4, 0));
      send_poll(mk_poll(1, 0, 0, 0, 0, 0, -5, 0));
      send_poll(mk_poll(1, 0, -100, 0, 0, 0, 5, 0));
      send_poll(mk_poll(1, 0, 20, 0, 19, -19, 0, 1000));          // stick on the edge
      send_poll(mk_poll(1, 0, 20, 0, 20, -20, 0, 1000));
      send_poll(mk_poll(1, 0, -20, 0, 20, -20, 0, 1000));         // timer hits floor
      send_poll(mk_poll(1, 0, -20, 21, 0, 0, 0, 1000));           // floor must not wrap
      send_poll(mk_poll(1, 0, -128, 0, -128, 127, 0, 0));
      send_poll(mk_poll(1, 0, -21, -21, 0, 0, 0, 1000));          // up beats left
      send_poll(mk_poll(1, 64, 0, 0, 0, 0, 0, 0));
      send_poll(mk_poll(1, 0, 19, 19, 0, 0, 0, 0));
      send_poll(mk_poll(1, 0, 21, 0, 0, 0, 0, 0));
      wait_drained();
      p = mk_poll(1, 0, 0, 0, 0, 0, 0, 0);

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0:       begin dz_cfg = 20;  tdz_cfg = 5;   delay_cfg = 200;  end
            1:       begin dz_cfg = 0;   tdz_cfg = 0;   delay_cfg = 0;    end
            2:       begin dz_cfg = 100; tdz_cfg = 100; delay_cfg = 1000; end
            4:       begin dz_cfg = 10;  tdz_cfg = 30;  delay_cfg = 50;   end
            6:       begin dz_cfg = 1;   tdz_cfg = 1;   delay_cfg = 1;    end
            default: begin
               dz_cfg    = $urandom_range(100);
               tdz_cfg   = $urandom_range(100);
               delay_cfg = $urandom_range(1000);
            end
         endcase
         write_register(gkeq_pkg::CSR_DEAD_ZONE, dz_cfg);
         write_register(gkeq_pkg::CSR_TRIGGER_DEAD_ZONE, tdz_cfg);
         write_register(gkeq_pkg::CSR_REPEAT_DELAY, delay_cfg);
         if (ph == 3) write_register(CSR_UNMAPPED, $urandom_range(1023));
         csr_valid <= 1'b0;

         case (ph % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 55; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 20; stall_pct = 20; end
         endcase

         for (i = 0; i < PHASE_POLLS; i++) begin
            if (ph == 0 && i == 10) hold_armed = 1'b1;
            if (ph == 5 && i == PHASE_POLLS / 2) wait_drained();
            p.connected = ($urandom_range(99) < 92);
            case ($urandom_range(9))
               0, 1, 2, 3: ;
               4, 5:       p.buttons = NB'($urandom_range(127));
               6, 7:       p.buttons ^= NB'(1) << $urandom_range(NB - 1);
               8:          p.buttons = '0;
               default:    p.buttons = '1;
            endcase
            p.stick_x = pick_axis(p.stick_x, int'(sb.dead_zone));
            p.stick_y = pick_axis(p.stick_y, int'(sb.dead_zone));
            p.dpad_x  = pick_axis(p.dpad_x, int'(sb.dead_zone));
            p.dpad_y  = pick_axis(p.dpad_y, int'(sb.dead_zone));
            p.trigger = pick_axis(p.trigger, int'(sb.trigger_dead_zone));
            case ($urandom_range(9))
               7, 8:    p.elapsed_ms = DW'($urandom_range(1000));
               9:       p.elapsed_ms = $urandom_range(1) ? DW'(1000) : DW'(0);
               default: p.elapsed_ms = DW'($urandom_range(120));
            endcase
            send_poll(p);
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
